// ----- rtl/additive_energy_counter_defines.svh -----
// Assertion helpers used by the checker of this block.
`ifndef ADDITIVE_ENERGY_COUNTER_DEFINES_SVH
`define ADDITIVE_ENERGY_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AEC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/aec_pkg.sv -----
package aec_pkg;

  localparam int unsigned IN_W     = 10;
  localparam int unsigned ENERGY_W = 33;
  localparam int unsigned SIZE_W   = 9;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_LDI   = 8'b0000_0100,
    S_PAIR  = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_FLUSH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage

// ----- rtl/aec_in_if.sv -----
interface aec_in_if;
  import aec_pkg::*;

  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   element_value;
  logic              last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

// ----- rtl/aec_out_if.sv -----
interface aec_out_if;
  import aec_pkg::*;

  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;
  logic [SIZE_W-1:0]   set_size;
  logic                overflow;

  modport source (output valid, output energy, output set_size, output overflow, input ready);
  modport sink   (input valid, input energy, input set_size, input overflow, output ready);
endinterface

// ----- rtl/additive_energy_counter.sv -----
// While loading, a new element is taken every cycle.
// After the last element of an n-element set, the n*n pair sums pass one per
// cycle, with an element fetch between rows, through the sum-count memory's
// read-modify-write loop, then one squared count per cycle in the scan.
// After reset every entry of the sum-count memory is swept to zero before the
// first element is taken; control state resets asynchronously.
module additive_energy_counter #(
  parameter int unsigned MAX_ELEMS  = 256,
  parameter int unsigned VALUE_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  aec_in_if.sink           elem_i,
  aec_out_if.source        res_o
);
  import aec_pkg::*;

  localparam int unsigned VB     = VALUE_BITS;
  localparam int unsigned SUM_AW = VB + 1;
  localparam int unsigned SUM_D  = 1 << SUM_AW;
  localparam int unsigned CW     = $clog2(MAX_ELEMS + 1);
  localparam int unsigned IW     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int unsigned CNTW   = $clog2(MAX_ELEMS * MAX_ELEMS + 1);

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, i_q, j_q;
  logic [VB-1:0]     max_q, a_q;
  logic              drop_q;
  logic              ld_v_q, p1_v_q, c_v_q, w_v_q, sv_q;
  logic [SUM_AW-1:0] c_addr_q, w_addr_q, sv_addr_q, s_q, clr_q;
  logic [CNTW-1:0]   w_data_q;

  logic                out_v_q;
  logic [ENERGY_W-1:0] energy_q;
  logic [SIZE_W-1:0]   size_q;
  logic                ovf_q;

  logic          in_fire, out_fire, has_room, j_last, i_last, drained, out_free;
  logic [VB-1:0] v;

  logic          e_we;
  logic [IW-1:0] e_raddr;
  logic [VB-1:0] e_rdata;

  logic [SUM_AW-1:0] pair_sum, s_raddr, s_waddr;
  logic              s_we;
  logic [CNTW-1:0]   s_wdata, s_rdata, inc;

  mac_ctrl_t           mac_ctrl;
  logic [ENERGY_W-1:0] acc;
  logic                mac_busy;

  assign v        = VB'(elem_i.element_value);
  assign in_fire  = elem_i.valid && elem_i.ready;
  assign out_fire = out_v_q && res_o.ready;
  assign out_free = !out_v_q || res_o.ready;
  assign has_room = cnt_q < CW'(MAX_ELEMS);
  assign j_last   = j_q == cnt_q - CW'(1);
  assign i_last   = i_q == cnt_q - CW'(1);
  assign drained  = !p1_v_q && !c_v_q;

  assign elem_i.ready = state_q == S_LOAD;

  // Element store.
  assign e_we    = in_fire && has_room;
  assign e_raddr = (state_q == S_LDI) ? i_q[IW-1:0] : j_q[IW-1:0];

  aec_ram #(.WIDTH(VB), .DEPTH(MAX_ELEMS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (v),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  // Sum-count store: zeroed after reset, increments during counting, read and zeroed during the scan.
  assign pair_sum = {1'b0, a_q} + {1'b0, e_rdata};
  assign s_raddr  = (state_q == S_SCAN) ? s_q : pair_sum;

  // A count written in the previous cycle is not yet visible to a read issued
  // in that same cycle, so it is forwarded.
  assign inc = ((w_v_q && (w_addr_q == c_addr_q)) ? w_data_q : s_rdata) + CNTW'(1);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = c_addr_q;
    s_wdata = inc;
    if (state_q == S_CLEAR) begin
      s_we    = 1'b1;
      s_waddr = clr_q;
      s_wdata = '0;
    end else if (c_v_q) begin
      s_we    = 1'b1;
    end else if (sv_q) begin
      s_we    = 1'b1;
      s_waddr = sv_addr_q;
      s_wdata = '0;
    end
  end

  aec_ram #(.WIDTH(CNTW), .DEPTH(SUM_D)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign mac_ctrl.valid = sv_q;
  assign mac_ctrl.clear = (state_q == S_DRAIN) && drained;

  aec_mac #(.CNT_W(CNTW)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .cnt_i  (s_rdata),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_LOAD;
      S_LOAD:  if (in_fire && elem_i.last_element) state_d = S_LDI;
      S_LDI:   state_d = S_PAIR;
      S_PAIR: begin
        if (j_last) begin
          state_d = i_last ? S_DRAIN : S_LDI;
        end
      end
      S_DRAIN: if (drained) state_d = S_SCAN;
      S_SCAN:  if (s_q == {max_q, 1'b0}) state_d = S_FLUSH;
      S_FLUSH: if (!sv_q && !mac_busy) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_LOAD;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      max_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      s_q     <= '0;
      ld_v_q  <= 1'b0;
      p1_v_q  <= 1'b0;
      c_v_q   <= 1'b0;
      w_v_q   <= 1'b0;
      sv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ld_v_q  <= state_q == S_LDI;
      p1_v_q  <= state_q == S_PAIR;
      c_v_q   <= p1_v_q;
      w_v_q   <= c_v_q;
      sv_q    <= state_q == S_SCAN;

      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + SUM_AW'(1);
      end

      if (in_fire) begin
        if (has_room) begin
          cnt_q <= cnt_q + CW'(1);
          if (v > max_q) begin
            max_q <= v;
          end
        end else begin
          drop_q <= 1'b1;
        end
        i_q <= '0;
        j_q <= '0;
      end

      if (state_q == S_PAIR) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end

      if (state_q == S_DRAIN) begin
        s_q <= '0;
      end else if (state_q == S_SCAN) begin
        s_q <= s_q + SUM_AW'(1);
      end

      if ((state_q == S_DONE) && out_free) begin
        out_v_q <= 1'b1;
        cnt_q   <= '0;
        max_q   <= '0;
        drop_q  <= 1'b0;
      end else if (out_fire) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_v_q) begin
      a_q <= e_rdata;
    end
    c_addr_q  <= pair_sum;
    w_addr_q  <= c_addr_q;
    w_data_q  <= inc;
    sv_addr_q <= s_q;
    if ((state_q == S_DONE) && out_free) begin
      energy_q <= acc;
      size_q   <= SIZE_W'(cnt_q);
      ovf_q    <= drop_q;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.energy   = energy_q;
  assign res_o.set_size = size_q;
  assign res_o.overflow = ovf_q;

endmodule

// ----- rtl/aec_ram.sv -----
module aec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Read-first: a read of the address written in the same cycle returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/aec_mac.sv -----
module aec_mac #(
  parameter int unsigned CNT_W = 17
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  aec_pkg::mac_ctrl_t           ctrl_i,
  input  logic [CNT_W-1:0]             cnt_i,
  output logic [aec_pkg::ENERGY_W-1:0] acc_o,
  output logic                         busy_o
);
  import aec_pkg::*;

  localparam int unsigned SQ_W  = 2 * CNT_W;
  localparam int unsigned SUM_W = (SQ_W > ENERGY_W ? SQ_W : ENERGY_W) + 1;

  logic                sq_v_q;
  logic [SQ_W-1:0]     sq_q;
  logic [ENERGY_W-1:0] acc_q;
  logic [SUM_W-1:0]    sum;

  assign sum = SUM_W'(acc_q) + SUM_W'(sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
    end else begin
      sq_v_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= SQ_W'(cnt_i) * SQ_W'(cnt_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (sq_v_q) begin
      acc_q <= (sum > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = sq_v_q;

endmodule

// ----- rtl/aec_checker.sv -----
`include "additive_energy_counter_defines.svh"

module aec_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [aec_pkg::ENERGY_W-1:0] energy_i,
  input logic [aec_pkg::SIZE_W-1:0]   set_size_i
);
  import aec_pkg::*;

  `AEC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result withdrawn before transfer")
  `AEC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(energy_i), "energy changed while stalled")
  `AEC_ASSERT_SAME(a_size_nonzero, clk_i, rst_ni, out_valid_i, set_size_i != '0, "result for an empty set")
  `AEC_ASSERT_SAME(a_energy_floor, clk_i, rst_ni, out_valid_i, energy_i >= ENERGY_W'(set_size_i), "energy below set size")
  `AEC_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "input taken during computation")

endmodule

bind additive_energy_counter aec_checker u_aec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (elem_i.valid),
  .in_ready_i  (elem_i.ready),
  .in_last_i   (elem_i.last_element),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .energy_i    (res_o.energy),
  .set_size_i  (res_o.set_size)
);
